/* rtl/oal_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered array list package
// Item types, operation and status codes, and sequencer states shared by the
// ordered array list engine.
// ----------------------------------------------------------------------------
package oal_pkg;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned FPOS_W = 6;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [KIND_W-1:0] {
    K_INSERT = 3'd0,
    K_DELETE = 3'd1,
    K_FIND   = 3'd2,
    K_GET    = 3'd3,
    K_UPDATE = 3'd4
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_CHECK,
    SQ_RUN,
    SQ_FINAL,
    SQ_RESP
  } seq_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic [FPOS_W-1:0]       found_position;
    logic [CNT_W-1:0]        entry_count;
    logic                    is_empty;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

/* rtl/oal_store.sv */
// ----------------------------------------------------------------------------
// Ordered array list entry store
// Single write port and single read port memory with registered read data.
// ----------------------------------------------------------------------------
module oal_store #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 32,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/oal_seq.sv */
// ----------------------------------------------------------------------------
// Ordered array list sequencer
// Checks each request and walks the entry store one entry per cycle to shift,
// search or read, using a single shared address counter and comparator.
// ----------------------------------------------------------------------------
module oal_seq import oal_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned AW        = $clog2(CAPACITY),
  localparam int unsigned CW        = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  in_item_t              item,
  input  logic                  out_free,
  output seq_stat_t             stat,
  output out_item_t             result,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [DATA_WIDTH-1:0] wr_data,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [DATA_WIDTH-1:0] rd_data
);

  localparam int unsigned MW = (CW > POS_W) ? CW : POS_W;

  seq_state_t            state_r, state_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic [AW-1:0]         src_r, src_nxt;
  logic [AW-1:0]         tag_r, tag_nxt;
  logic                  pend_r, pend_nxt;
  status_t               status_r, status_nxt;
  logic [VAL_W-1:0]      rdv_r, rdv_nxt;
  logic [FPOS_W-1:0]     fpos_r, fpos_nxt;
  logic                  done;

  logic [MW-1:0] pos_m;
  logic [MW-1:0] cnt_m;
  logic [MW-1:0] cap_m;
  logic [AW-1:0] pos_a;

  assign pos_m = MW'(pos_r);
  assign cnt_m = MW'(count_r);
  assign cap_m = MW'(CAPACITY);
  assign pos_a = AW'(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      count_r <= '0;
      left_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    src_r    <= src_nxt;
    tag_r    <= tag_nxt;
    status_r <= status_nxt;
    rdv_r    <= rdv_nxt;
    fpos_r   <= fpos_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    key_nxt    = key_r;
    count_nxt  = count_r;
    left_nxt   = left_r;
    src_nxt    = src_r;
    tag_nxt    = tag_r;
    pend_nxt   = pend_r;
    status_nxt = status_r;
    rdv_nxt    = rdv_r;
    fpos_nxt   = fpos_r;
    wr_en      = 1'b0;
    wr_addr    = pos_a;
    wr_data    = key_r;
    rd_en      = 1'b0;
    rd_addr    = src_r;
    done       = 1'b0;

    unique case (state_r)
      SQ_IDLE: begin
        if (start) begin
          kind_nxt  = item.kind;
          pos_nxt   = item.position;
          key_nxt   = DATA_WIDTH'($unsigned(item.value));
          pend_nxt  = 1'b0;
          state_nxt = SQ_CHECK;
        end
      end

      SQ_CHECK: begin
        status_nxt = ST_OK;
        rdv_nxt    = '0;
        fpos_nxt   = '0;
        left_nxt   = '0;
        state_nxt  = SQ_RESP;
        case (kind_r)
          K_INSERT: begin
            if (pos_m > cnt_m) begin
              status_nxt = ST_BADPOS;
            end else if (cnt_m == cap_m) begin
              status_nxt = ST_FULL;
            end else begin
              left_nxt  = CW'(cnt_m - pos_m);
              src_nxt   = AW'(count_r - 1'b1);
              state_nxt = SQ_RUN;
            end
          end
          K_DELETE: begin
            if (pos_m >= cnt_m) begin
              status_nxt = ST_BADPOS;
            end else begin
              left_nxt  = CW'(cnt_m - pos_m - 1'b1);
              src_nxt   = pos_a + 1'b1;
              state_nxt = SQ_RUN;
            end
          end
          K_FIND: begin
            status_nxt = ST_NOTFOUND;
            left_nxt   = count_r;
            src_nxt    = '0;
            state_nxt  = SQ_RUN;
          end
          K_GET: begin
            if (pos_m >= cnt_m) begin
              status_nxt = ST_BADPOS;
            end else begin
              left_nxt  = CW'(1);
              src_nxt   = pos_a;
              state_nxt = SQ_RUN;
            end
          end
          K_UPDATE: begin
            if (pos_m >= cnt_m) begin
              status_nxt = ST_BADPOS;
            end else begin
              wr_en   = 1'b1;
              wr_addr = pos_a;
              wr_data = key_r;
            end
          end
          default: begin
            status_nxt = ST_BADPOS;
          end
        endcase
      end

      SQ_RUN: begin
        rd_en   = (left_r != '0);
        rd_addr = src_r;
        if (rd_en) begin
          left_nxt = left_r - 1'b1;
          src_nxt  = (kind_r == K_INSERT) ? src_r - 1'b1 : src_r + 1'b1;
          tag_nxt  = src_r;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (!rd_en && !pend_r) begin
          state_nxt = SQ_FINAL;
        end
        if (pend_r) begin
          case (kind_r)
            K_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = tag_r + 1'b1;
              wr_data = rd_data;
            end
            K_DELETE: begin
              wr_en   = 1'b1;
              wr_addr = tag_r - 1'b1;
              wr_data = rd_data;
            end
            K_FIND: begin
              if (rd_data == key_r) begin
                status_nxt = ST_OK;
                fpos_nxt   = FPOS_W'(tag_r);
                left_nxt   = '0;
                pend_nxt   = 1'b0;
                state_nxt  = SQ_RESP;
              end
            end
            K_GET: begin
              rdv_nxt = VAL_W'(rd_data);
            end
            default: begin
            end
          endcase
        end
      end

      SQ_FINAL: begin
        case (kind_r)
          K_INSERT: begin
            wr_en     = 1'b1;
            wr_addr   = pos_a;
            wr_data   = key_r;
            count_nxt = count_r + 1'b1;
          end
          K_DELETE: begin
            count_nxt = count_r - 1'b1;
          end
          default: begin
          end
        endcase
        state_nxt = SQ_RESP;
      end

      SQ_RESP: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = SQ_IDLE;
        end
      end

      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  assign stat.idle = (state_r == SQ_IDLE);
  assign stat.done = done;

  assign result.status         = status_r;
  assign result.read_value     = rdv_r;
  assign result.found_position = fpos_r;
  assign result.entry_count    = CNT_W'(count_r);
  assign result.is_empty       = (count_r == '0);

endmodule

/* rtl/ordered_array_list_engine_core.sv */
// ----------------------------------------------------------------------------
// Ordered array list engine
// A result reaches the output register through the check state for update and refused requests,
// and through a walk of the entry store for get, insert, delete and find, where the walk spans the
// one entry read or the N entries moved or compared; the worst case is find on a full list.
// A result waits in the sequencer for as long as out_stall holds a full output register.
// The next item is accepted in the cycle after the result is loaded; one item is worked at a time.
// Reset clears the entry count and the control state; the entry store needs no clearing pass.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_core import oal_pkg::*; #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int unsigned AW = $clog2(CAPACITY);

  seq_stat_t             stat;
  out_item_t             result;
  logic                  start;
  logic                  out_free;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  assign in_stall = !stat.idle;
  assign start    = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  oal_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item     (in_item),
    .out_free (out_free),
    .stat     (stat),
    .result   (result),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  oal_store #(
    .DEPTH  (CAPACITY),
    .DATA_W (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
